@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition seen at one edge implies another at the next edge.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bdlp_pkg.sv @@
`timescale 1ns / 1ps
package bdlp_pkg;

  // Event codes as they appear in event_code
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_PRESSED  = 2'd1;
  localparam logic [1:0] EV_RELEASED = 2'd2;
  localparam logic [1:0] EV_LONG     = 2'd3;

  // Register indexes on the write port
  localparam logic [1:0] CFG_ACTIVE_LOW_MASK = 2'd0;
  localparam logic [1:0] CFG_DEBOUNCE_MS     = 2'd1;
  localparam logic [1:0] CFG_LONG_PRESS_MS   = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register values after reset
  localparam logic [7:0]  ACTIVE_LOW_MASK_RST = 8'd0;
  localparam logic [15:0] DEBOUNCE_MS_RST     = 16'd50;
  localparam logic [15:0] LONG_PRESS_MS_RST   = 16'd1000;

  typedef struct packed {
    logic [2:0]  button_index;
    logic        pin_level;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  button_out;
    logic [1:0]  event_code;
    logic        event_new;
    logic        is_pressed;
    logic [31:0] held_ms;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  active_low_mask;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  // Per-button state entry
  typedef struct packed {
    logic        last_raw;
    logic [31:0] stable_since;
    logic        pressed;
    logic [31:0] press_started;
    logic [1:0]  latched;
  } btn_state_t;

endpackage

@@ sv/bdlp_update.sv @@
`timescale 1ns / 1ps
module bdlp_update
  import bdlp_pkg::*;
(
  input  in_item_t   item,
  input  cfg_t       cfg,
  input  logic       in_range,
  input  btn_state_t cur,
  output btn_state_t nxt,
  output out_item_t  res
);

  logic        act;
  logic        flip;
  logic        long_hit;
  logic [31:0] stable_age;
  logic [31:0] held;

  always_comb begin
    nxt      = cur;
    res      = '0;
    flip     = 1'b0;
    long_hit = 1'b0;
    held     = '0;
    res.button_out = item.button_index;

    // Map pin level to active through the polarity mask
    act = item.pin_level ^ cfg.active_low_mask[item.button_index];

    // Restart the debounce timestamp on any change
    if (act != cur.last_raw) begin
      nxt.last_raw     = act;
      nxt.stable_since = item.time_ms;
    end
    stable_age = item.time_ms - nxt.stable_since;

    // Flip the debounced state once stable long enough
    if (stable_age > {16'd0, cfg.debounce_ms} && act != cur.pressed) begin
      flip        = 1'b1;
      nxt.pressed = act;
      if (act) begin
        nxt.press_started = item.time_ms;
        nxt.latched       = EV_PRESSED;
      end else begin
        nxt.latched = EV_RELEASED;
      end
    end

    // Track held time and raise long press once per press
    if (nxt.pressed) begin
      held = item.time_ms - nxt.press_started;
      if (held >= {16'd0, cfg.long_press_ms} && nxt.latched != EV_LONG) begin
        nxt.latched = EV_LONG;
        long_hit    = 1'b1;
      end
    end

    // Report only for buttons that exist
    if (in_range) begin
      res.event_code = nxt.latched;
      res.event_new  = flip | long_hit;
      res.is_pressed = nxt.pressed;
      res.held_ms    = held;
    end
  end

endmodule

@@ sv/button_debounce_long_press.sv @@
`timescale 1ns / 1ps
// Debounced buttons with pressed, released and long-press events.
// Input channel (in_valid / in_stall / in_item): one sample of one button per
// item: button index, pin level and the free-running millisecond time.
// Output channel (out_valid / out_stall / out_item): exactly one result item
// per input item, in order: latched event, new-event flag, debounced state
// and held time. Samples for an index at or beyond NUM_BUTTONS give a result
// with all fields but the index at zero and leave every button untouched.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 polarity
// mask, 1 debounce time, 2 long-press time); other indexes are ignored.
// Write only while no item is in flight.
// Path: an accepted item waits in the input register, and its result moves to the
// result register as the item advances; there it stays until it is taken.
// Throughput: one item per cycle while out_stall is low; the per-button state is
// read and written once per item by a single compare-and-subtract path between
// the input register and the result register.
// Reset (rst, synchronous): clears all button state and loads the register
// defaults; both channels come up empty.
// Stall: a stalled result is held; the input register keeps one more item,
// after which in_stall rises until the result is taken.
module button_debounce_long_press
  import bdlp_pkg::*;
#(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  cfg_t       cfg;
  logic       s1_valid;
  in_item_t   s1_item;
  logic       s1_advance;
  logic       in_range;
  logic [IDX_W-1:0] idx;
  btn_state_t state [NUM_BUTTONS];
  btn_state_t cur;
  btn_state_t nxt;
  out_item_t  res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_low_mask <= ACTIVE_LOW_MASK_RST;
      cfg.debounce_ms     <= DEBOUNCE_MS_RST;
      cfg.long_press_ms   <= LONG_PRESS_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTIVE_LOW_MASK: cfg.active_low_mask <= cfg_data[7:0];
        CFG_DEBOUNCE_MS:     cfg.debounce_ms     <= cfg_data;
        CFG_LONG_PRESS_MS:   cfg.long_press_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: input register advances when the result slot is free
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  // Select the button entry
  assign in_range = (32'(s1_item.button_index) < NUM_BUTTONS);
  assign idx      = IDX_W'(s1_item.button_index);
  assign cur      = state[idx];

  bdlp_update u_update (
    .item     (s1_item),
    .cfg      (cfg),
    .in_range (in_range),
    .cur      (cur),
    .nxt      (nxt),
    .res      (res)
  );

  // Write back the button entry as the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        state[k] <= '0;
      end
    end else if (s1_advance && in_range) begin
      state[idx] <= nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_item <= res;
    end
  end

endmodule

@@ sv/bdlp_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bdlp_checker
  import bdlp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // Hold a stalled result
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

  // Debounced state agrees with the latched event
  `CHK_ALWAYS(a_state_vs_event, !out_valid || (out_item.is_pressed == (out_item.event_code == EV_PRESSED || out_item.event_code == EV_LONG)), "pressed state disagrees with event")

  // Released buttons report no held time
  `CHK_ALWAYS(a_released_zero, !out_valid || out_item.is_pressed || out_item.held_ms == 32'd0, "held time while released")

  // Output channel comes up empty after reset
  `CHK_ALWAYS(a_empty_after_rst, !$past(rst) || !out_valid, "result valid right after reset")

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
